// ===== rtl/sle_pkg.sv =====
`timescale 1ns / 1ps
package sle_pkg;

  // Store geometry
  localparam int LINE_LEN   = 64;
  localparam int HIST_DEPTH = 16;
  localparam int MAXLEN     = LINE_LEN - 1;
  localparam int LW         = $clog2(LINE_LEN);
  localparam int HW         = $clog2(HIST_DEPTH);
  localparam int CW         = $clog2(HIST_DEPTH + 1);
  localparam int HAW        = $clog2(HIST_DEPTH * LINE_LEN);

  // Key codes
  localparam logic [7:0] KEY_ESC  = 8'd27;
  localparam logic [7:0] KEY_DEL  = 8'd127;
  localparam logic [7:0] KEY_BS   = 8'd8;
  localparam logic [7:0] KEY_EOT  = 8'd4;
  localparam logic [7:0] KEY_ETX  = 8'd3;
  localparam logic [7:0] KEY_LF   = 8'd10;
  localparam logic [7:0] KEY_CR   = 8'd13;
  localparam logic [7:0] KEY_LBR  = 8'h5B;
  localparam logic [7:0] KEY_O    = 8'h4F;
  localparam logic [7:0] KEY_TLD  = 8'h7E;
  localparam logic [7:0] KEY_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    EV_NONE, EV_EDIT, EV_MOVE, EV_RECALL, EV_LINE, EV_CANCEL, EV_EOF
  } ev_t;

  typedef enum logic [1:0] {
    MODE_NORMAL, MODE_ESC, MODE_INTRO, MODE_PARAM
  } mode_t;

  typedef enum logic [3:0] {
    A_NOP, A_LEFT, A_RIGHT, A_HOME, A_END, A_DEL, A_BS, A_INS,
    A_ENTER, A_UP, A_DOWN, A_CANCEL, A_EOF
  } act_t;

  typedef enum logic [1:0] {
    CK_SAVE, CK_HIST, CK_REST, CK_PUSH
  } cp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SH_RD, ST_SH_WR, ST_INS_WR, ST_SC_RD, ST_SC_CK,
    ST_CP_RD, ST_CP_WR, ST_LD_LEN, ST_LD_WAIT, ST_EM_RD, ST_EM_OUT, ST_RESP
  } state_t;

endpackage

// ===== rtl/sle_if.sv =====
`timescale 1ns / 1ps
// Key byte channel
interface sle_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  modport source (output valid, output key_byte, input ready);
  modport sink (input valid, input key_byte, output ready);
endinterface

// Result word channel
interface sle_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [5:0] caret_pos;
  logic [5:0] line_length;
  logic [7:0] line_char;
  logic       last_of_run;
  modport source (output valid, output event_res, output caret_pos, output line_length,
                  output line_char, output last_of_run, input ready);
  modport sink (input valid, input event_res, input caret_pos, input line_length,
                input line_char, input last_of_run, output ready);
endinterface

// ===== rtl/serial_console_line_editor.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Word fields
// key_in    in   key_byte[7:0]
// res_out   out  event_res[2:0] caret_pos[5:0] line_length[5:0] line_char[7:0] last_of_run
//
// One key at a time. Moves, cancel and escape bytes: one result word, held until taken.
// Insert/delete/backspace: each shifted byte is read, then written back (single-port line store).
// Enter: a scan of the line, a history copy when stored, then one result word per emitted byte.
// Recall: a save of the edited line when needed, then a load. rst is synchronous; stores are not cleared.
// A stalled result holds the block; no key is taken until the last result of a key leaves.
module serial_console_line_editor import sle_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sle_key_if.sink      key_in,
  sle_res_if.source    res_out
);

  state_t state, state_next;

  logic [LW-1:0] cursor, length, saved_len, idx, cnt, emit_n;
  logic          saved_valid, browsing, blank, eq;
  mode_t         mode, mode_next;
  logic          intro_o, intro_next;
  logic [7:0]    pdig, pdig_next, ins_c;
  logic [2:0]    pcnt, pcnt_next;
  logic [HW-1:0] newest, view;
  logic [CW-1:0] entry_count;
  act_t          act, act_r;
  cp_t           cp_kind;
  ev_t           ev_r;

  // RAM ports
  logic [LW-1:0]  line_addr, sav_addr;
  logic           line_we, sav_we, hist_we, hl_we;
  logic [7:0]     line_wd, sav_wd, hist_wd, line_rd, sav_rd, hist_rd;
  logic [HAW-1:0] hist_addr;
  logic [HW-1:0]  hl_addr, hist_slot;
  logic [LW-1:0]  hl_wd, hl_rd;

  sle_ram #(.W(8), .D(LINE_LEN)) u_line (
    .clk(clk), .we(line_we), .addr(line_addr), .wdata(line_wd), .rdata(line_rd));
  sle_ram #(.W(8), .D(LINE_LEN)) u_saved (
    .clk(clk), .we(sav_we), .addr(sav_addr), .wdata(sav_wd), .rdata(sav_rd));
  sle_ram #(.W(8), .D(HIST_DEPTH * LINE_LEN)) u_hist (
    .clk(clk), .we(hist_we), .addr(hist_addr), .wdata(hist_wd), .rdata(hist_rd));
  sle_ram #(.W(LW), .D(HIST_DEPTH)) u_hlen (
    .clk(clk), .we(hl_we), .addr(hl_addr), .wdata(hl_wd), .rdata(hl_rd));

  // Helpers
  logic          acc, res_acc, left, sh_done, sc_done, cp_done, push_ok, em_last;
  logic          up_go, up_save, line_blank;
  logic [HW+1:0] old_sum;
  logic [HW-1:0] oldest, newest_inc, view_inc, view_dec;
  logic [7:0]    c;

  assign c        = key_in.key_byte;
  assign acc      = key_in.valid && key_in.ready;
  assign res_acc  = res_out.valid && res_out.ready;
  assign left     = (act_r != A_INS);
  assign sh_done  = left ? ((LW+1)'(idx) + (LW+1)'(1) >= (LW+1)'(length)) : (idx <= cursor);
  assign sc_done  = (idx == emit_n);
  assign cp_done  = (idx == cnt);
  assign push_ok  = !blank && !eq;
  assign em_last  = ((LW+1)'(idx) + (LW+1)'(1) == (LW+1)'(emit_n));
  assign line_blank = (line_rd == 8'd32) || (line_rd >= 8'd9 && line_rd <= 8'd13);

  assign old_sum = (HW+2)'(newest) + (HW+2)'(HIST_DEPTH) + (HW+2)'(1) - (HW+2)'(entry_count);
  assign oldest  = (old_sum >= (HW+2)'(HIST_DEPTH)) ? HW'(old_sum - (HW+2)'(HIST_DEPTH))
                                                   : HW'(old_sum);
  assign newest_inc = (newest == HW'(HIST_DEPTH - 1)) ? '0 : newest + HW'(1);
  assign view_inc   = (view == HW'(HIST_DEPTH - 1)) ? '0 : view + HW'(1);
  assign view_dec   = (view == '0) ? HW'(HIST_DEPTH - 1) : view - HW'(1);
  assign up_go   = (entry_count != '0) && (!browsing || view != oldest);
  assign up_save = !saved_valid && (length != '0);

  // Key decoder
  always_comb begin
    mode_next  = mode;
    intro_next = intro_o;
    pdig_next  = pdig;
    pcnt_next  = pcnt;
    act        = A_NOP;
    case (mode)
      MODE_ESC: begin
        if (c == KEY_LBR || c == KEY_O) begin
          mode_next  = MODE_INTRO;
          intro_next = (c == KEY_O);
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_INTRO: begin
        mode_next = MODE_NORMAL;
        if (intro_o) begin
          if (c == "H") act = A_HOME;
          else if (c == "F") act = A_END;
        end else if (c == "A") act = A_UP;
        else if (c == "B") act = A_DOWN;
        else if (c == "C") act = A_RIGHT;
        else if (c == "D") act = A_LEFT;
        else if (c == "H") act = A_HOME;
        else if (c == "F") act = A_END;
        else if (c inside {["0":"9"]}) begin
          mode_next = MODE_PARAM;
          pdig_next = c;
          pcnt_next = 3'd1;
        end
      end
      MODE_PARAM: begin
        if (c == KEY_TLD) begin
          mode_next = MODE_NORMAL;
          if (pcnt == 3'd1) begin
            if (pdig == "3") act = A_DEL;
            else if (pdig inside {"1", "7"}) act = A_HOME;
            else if (pdig inside {"4", "8"}) act = A_END;
          end
        end else if (c inside {["0":"9"]} || c == KEY_SEMI) begin
          if (pcnt != 3'd7) pcnt_next = pcnt + 3'd1;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        if (c == KEY_ESC) begin
          mode_next = MODE_ESC;
          pcnt_next = 3'd0;
        end else if (c == KEY_DEL || c == KEY_BS) act = A_BS;
        else if (c == KEY_LF || c == KEY_CR) act = A_ENTER;
        else if (c == KEY_EOT) act = A_EOF;
        else if (c == KEY_ETX) act = A_CANCEL;
        else if (c inside {[8'd32:8'd126]}) act = A_INS;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (act)
            A_DEL:   state_next = (cursor < length) ? ST_SH_RD : ST_RESP;
            A_BS:    state_next = (cursor != '0) ? ST_SH_RD : ST_RESP;
            A_INS:   state_next = (length < LW'(MAXLEN)) ? ST_SH_RD : ST_RESP;
            A_ENTER: state_next = ST_SC_RD;
            A_UP:    state_next = !up_go ? ST_RESP : (up_save ? ST_CP_RD : ST_LD_LEN);
            A_DOWN: begin
              if (!browsing) state_next = ST_RESP;
              else if (view != newest) state_next = ST_LD_LEN;
              else state_next = saved_valid ? ST_CP_RD : ST_RESP;
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_SH_RD: begin
        if (!sh_done) state_next = ST_SH_WR;
        else state_next = left ? ST_RESP : ST_INS_WR;
      end
      ST_SH_WR:  state_next = ST_SH_RD;
      ST_INS_WR: state_next = ST_RESP;
      ST_SC_RD: begin
        if (!sc_done) state_next = ST_SC_CK;
        else if (push_ok) state_next = ST_CP_RD;
        else state_next = (emit_n == '0) ? ST_RESP : ST_EM_RD;
      end
      ST_SC_CK: state_next = ST_SC_RD;
      ST_CP_RD: begin
        if (!cp_done) state_next = ST_CP_WR;
        else begin
          case (cp_kind)
            CK_SAVE: state_next = ST_LD_LEN;
            CK_PUSH: state_next = ST_EM_RD;
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_CP_WR:   state_next = ST_CP_RD;
      ST_LD_LEN:  state_next = ST_LD_WAIT;
      ST_LD_WAIT: state_next = ST_CP_RD;
      ST_EM_RD:   state_next = ST_EM_OUT;
      ST_EM_OUT: begin
        if (res_acc) state_next = em_last ? ST_IDLE : ST_EM_RD;
      end
      ST_RESP: begin
        if (res_acc) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and store control
  always_comb begin
    key_in.ready = (state == ST_IDLE);
    res_out.valid = (state == ST_RESP) || (state == ST_EM_OUT);
    res_out.event_res   = ev_r;
    res_out.caret_pos   = 6'(cursor);
    res_out.line_length = 6'(length);
    res_out.line_char   = (state == ST_EM_OUT) ? line_rd : 8'd0;
    res_out.last_of_run = (state == ST_RESP) ? 1'b1 : em_last;

    line_addr = idx;
    line_we   = 1'b0;
    line_wd   = line_rd;
    sav_addr  = idx;
    sav_we    = 1'b0;
    sav_wd    = line_rd;
    hist_we   = 1'b0;
    hist_wd   = line_rd;
    hl_addr   = newest;
    hl_we     = 1'b0;
    hl_wd     = emit_n;
    hist_slot = newest;

    case (state)
      ST_SH_RD:  line_addr = left ? idx + LW'(1) : idx - LW'(1);
      ST_SH_WR:  line_we = 1'b1;
      ST_INS_WR: begin
        line_addr = cursor;
        line_we   = 1'b1;
        line_wd   = ins_c;
      end
      ST_SC_RD: begin
        if (sc_done && push_ok) begin
          hl_addr = newest_inc;
          hl_we   = 1'b1;
        end
      end
      ST_CP_RD: begin
        if (cp_kind == CK_HIST) hist_slot = view;
      end
      ST_CP_WR: begin
        case (cp_kind)
          CK_SAVE: sav_we = 1'b1;
          CK_PUSH: hist_we = 1'b1;
          CK_HIST: begin
            hist_slot = view;
            line_we   = 1'b1;
            line_wd   = hist_rd;
          end
          default: begin
            line_we = 1'b1;
            line_wd = sav_rd;
          end
        endcase
      end
      ST_LD_LEN: hl_addr = view;
      default: ;
    endcase
    hist_addr = HAW'(HAW'(hist_slot) * HAW'(LINE_LEN) + HAW'(idx));
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor      <= '0;
      length      <= '0;
      saved_len   <= '0;
      saved_valid <= 1'b0;
      browsing    <= 1'b0;
      mode        <= MODE_NORMAL;
      intro_o     <= 1'b0;
      pdig        <= '0;
      pcnt        <= '0;
      newest      <= HW'(HIST_DEPTH - 1);
      entry_count <= '0;
      view        <= '0;
      ev_r        <= EV_NONE;
      act_r       <= A_NOP;
      cp_kind     <= CK_SAVE;
      idx         <= '0;
      cnt         <= '0;
      emit_n      <= '0;
      blank       <= 1'b1;
      eq          <= 1'b0;
      ins_c       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            mode    <= mode_next;
            intro_o <= intro_next;
            pdig    <= pdig_next;
            pcnt    <= pcnt_next;
            act_r   <= act;
            ev_r    <= EV_NONE;
            case (act)
              A_LEFT: begin
                if (cursor != '0) begin
                  cursor <= cursor - LW'(1);
                  ev_r   <= EV_MOVE;
                end
              end
              A_RIGHT: begin
                if (cursor < length) begin
                  cursor <= cursor + LW'(1);
                  ev_r   <= EV_MOVE;
                end
              end
              A_HOME: begin
                if (cursor != '0) begin
                  cursor <= '0;
                  ev_r   <= EV_MOVE;
                end
              end
              A_END: begin
                if (cursor < length) begin
                  cursor <= length;
                  ev_r   <= EV_MOVE;
                end
              end
              A_EOF: ev_r <= (length == '0) ? EV_EOF : EV_NONE;
              A_CANCEL: begin
                length      <= '0;
                cursor      <= '0;
                saved_valid <= 1'b0;
                browsing    <= 1'b0;
                ev_r        <= EV_CANCEL;
              end
              A_DEL: begin
                idx <= cursor;
                if (cursor < length) ev_r <= EV_EDIT;
              end
              A_BS: begin
                idx <= cursor - LW'(1);
                if (cursor != '0) ev_r <= EV_EDIT;
              end
              A_INS: begin
                idx   <= length;
                ins_c <= c;
                if (length < LW'(MAXLEN)) ev_r <= EV_EDIT;
              end
              A_ENTER: begin
                emit_n      <= length;
                length      <= '0;
                cursor      <= '0;
                browsing    <= 1'b0;
                saved_valid <= 1'b0;
                idx         <= '0;
                blank       <= 1'b1;
                eq          <= (entry_count != '0);
                ev_r        <= EV_LINE;
              end
              A_UP: begin
                if (up_go) begin
                  ev_r <= EV_RECALL;
                  if (!browsing) begin
                    view     <= newest;
                    browsing <= 1'b1;
                  end else begin
                    view <= view_dec;
                  end
                  if (up_save) begin
                    saved_len   <= length;
                    saved_valid <= 1'b1;
                    cnt         <= length;
                    idx         <= '0;
                    cp_kind     <= CK_SAVE;
                  end
                end
              end
              A_DOWN: begin
                if (browsing) begin
                  ev_r <= EV_RECALL;
                  if (view == newest) begin
                    browsing <= 1'b0;
                    if (saved_valid) begin
                      length      <= saved_len;
                      cursor      <= saved_len;
                      cnt         <= saved_len;
                      idx         <= '0;
                      cp_kind     <= CK_REST;
                      saved_valid <= 1'b0;
                    end else begin
                      length <= '0;
                      cursor <= '0;
                    end
                  end else begin
                    view <= view_inc;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_SH_RD: begin
          if (sh_done && left) begin
            length   <= length - LW'(1);
            browsing <= 1'b0;
            if (act_r == A_BS) cursor <= cursor - LW'(1);
          end
        end
        ST_SH_WR: idx <= left ? idx + LW'(1) : idx - LW'(1);
        ST_INS_WR: begin
          cursor   <= cursor + LW'(1);
          length   <= length + LW'(1);
          browsing <= 1'b0;
        end
        ST_SC_RD: begin
          if (sc_done) begin
            idx <= '0;
            if (push_ok) begin
              newest  <= newest_inc;
              cnt     <= emit_n;
              cp_kind <= CK_PUSH;
              if (entry_count < CW'(HIST_DEPTH)) entry_count <= entry_count + CW'(1);
            end
          end
        end
        ST_SC_CK: begin
          blank <= blank && line_blank;
          eq    <= eq && (line_rd == hist_rd) && (hl_rd == emit_n);
          idx   <= idx + LW'(1);
        end
        ST_CP_RD: begin
          if (cp_done) idx <= '0;
        end
        ST_CP_WR: idx <= idx + LW'(1);
        ST_LD_WAIT: begin
          cnt     <= hl_rd;
          length  <= hl_rd;
          cursor  <= hl_rd;
          idx     <= '0;
          cp_kind <= CK_HIST;
        end
        ST_EM_OUT: begin
          if (res_acc && !em_last) idx <= idx + LW'(1);
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst) cursor <= length)
    else $error("cursor beyond line end");
  a_length_cap: assert property (@(posedge clk) disable iff (rst) length <= LW'(MAXLEN))
    else $error("line length over capacity");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(HIST_DEPTH))
    else $error("history count over depth");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(key_in.ready && res_out.valid))
    else $error("key taken while result pending");

endmodule

// ===== rtl/sle_ram.sv =====
`timescale 1ns / 1ps
// Single-port RAM, registered read
module sle_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
